@@ rtl/cas_pkg.sv @@
`default_nettype none

package cas_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WALL_THRESHOLD = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH    = 11'd64;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT   = 11'd64;
    localparam logic [3:0]            RST_WALL_THRESHOLD = 4'd5;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int POS_W = 10;
    localparam int THR_W = 4;

    localparam logic KIND_TILE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Where the result value of a request comes from
    typedef enum logic [1:0] {
        SRC_EDGE,    // right-border tile of the row above the current one
        SRC_CENTER,  // border tile, passes through
        SRC_COUNT,   // interior tile, neighbor count against threshold
        SRC_MIDDLE   // last row, read back from the middle line
    } src_t;

    // Request handed from the sequencer to the stencil stage
    typedef struct packed {
        logic             writes;  // tile request: line write-back and window shift
        logic             due;     // produces a result
        logic             last;
        src_t             src;
        logic             tile;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
    } stage_ctl_t;

endpackage

`default_nettype wire

@@ rtl/cellular_automaton_smoothing.sv @@
// Channel   Handshake                  Payload                      Direction
// tiles     tile_valid / tile_ready    kind, tile                   in
// results   result_valid/result_ready  column, row, tile_out, last  out
// config    cfg_write (no wait)        cfg_index, cfg_data          in
//
// One request per cycle sustained while results are taken. A request is sequenced in the accept cycle
// and its line-buffer read lands at the accepting edge; the stencil stage then
// writes the lines back and loads the output register once that register is free or
// being emptied, and the result is offered from the output register.
// The line buffers are single-bit memories of MAX_WIDTH entries; reads of an
// entry written in the same cycle are bypassed.
// Reset restores the register defaults and clears counters, window and
// handshake state; the lines need no clearing.
// A stalled result holds the stencil stage; tile_ready drops only once both the
// output register and the stencil stage are occupied.
`default_nettype none

module cellular_automaton_smoothing #(
    parameter int MAX_WIDTH  = cas_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cas_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [cas_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cas_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              tile_valid,
    output logic                                   tile_ready,
    input  wire logic                              kind,
    input  wire logic                              tile,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [cas_pkg::POS_W-1:0]              column,
    output logic [cas_pkg::POS_W-1:0]              row,
    output logic                                   tile_out,
    output logic                                   last
);
    import cas_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             accept;
    stage_ctl_t       req;
    logic             req_act;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] w_last;
    logic [THR_W-1:0] threshold;
    logic             rd_upper;
    logic             rd_middle;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic             wr_upper;
    logic             wr_middle;
    logic             stage_free;

    // a request is taken whenever the stencil stage frees up this cycle
    assign tile_ready = stage_free;
    assign accept     = tile_valid && tile_ready;

    // counters, geometry and per-request decisions
    cas_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .kind      (kind),
        .tile      (tile),
        .req       (req),
        .req_act   (req_act),
        .rd_addr   (rd_addr),
        .w_last    (w_last),
        .threshold (threshold)
    );

    // the two previous rows, one bit per column
    cas_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk       (clk),
        .rd_en     (req_act),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    // 3x3 window, neighbor count, write-back and output register
    cas_stencil #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stencil (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (req_act),
        .req          (req),
        .req_addr     (rd_addr),
        .w_last       (w_last),
        .threshold    (threshold),
        .rd_upper     (rd_upper),
        .rd_middle    (rd_middle),
        .free         (stage_free),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_upper     (wr_upper),
        .wr_middle    (wr_middle),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .column       (column),
        .row          (row),
        .tile_out     (tile_out),
        .last         (last)
    );

endmodule

`default_nettype wire

@@ rtl/cas_line_mem.sv @@
`default_nettype none

module cas_line_mem #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire logic                         wr_upper,
    input  wire logic                         wr_middle,
    output logic                              rd_upper,
    output logic                              rd_middle
);
    logic upper_mem  [MAX_WIDTH];
    logic middle_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    // Registered read; a write to the same entry in the same cycle is bypassed
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_upper  <= wr_upper;
                rd_middle <= wr_middle;
            end
            else
            begin
                rd_upper  <= upper_mem[rd_addr];
                rd_middle <= middle_mem[rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/cas_seq.sv @@
`default_nettype none

module cas_seq #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [cas_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cas_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              accept,
    input  wire logic                              kind,
    input  wire logic                              tile,
    output cas_pkg::stage_ctl_t                    req,
    output logic                                   req_act,
    output logic [$clog2(MAX_WIDTH)-1:0]           rd_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]           w_last,
    output logic [cas_pkg::THR_W-1:0]              threshold
);
    import cas_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [CFG_DATA_W-1:0] width_reg, width_next;
    logic [CFG_DATA_W-1:0] height_reg, height_next;
    logic [THR_W-1:0]      thr_reg, thr_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic                  taken_reg, taken_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;

    logic [ROW_W-1:0] h_last;
    logic             due;
    logic             interior;
    logic             is_last;
    logic             emit;

    // Clamped geometry, kept as last index
    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(width_reg - 11'd1);

        if (height_reg == '0)
            h_last = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_last = ROW_W'(MAX_HEIGHT - 1);
        else
            h_last = ROW_W'(height_reg - 11'd1);
    end

    assign threshold = thr_reg;

    assign due = (in_row_reg >= ROW_W'(2)) ||
                 ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
    assign interior = (out_col_reg != '0) && (out_col_reg < w_last) &&
                      (out_row_reg != '0) && (out_row_reg < h_last);
    assign is_last = (out_col_reg == w_last) && (out_row_reg == h_last);

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        thr_next     = thr_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        taken_next   = taken_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        req          = '0;
        rd_addr      = in_col_reg;
        emit         = 1'b0;

        if (accept)
        begin
            if (taken_reg)
            begin
                // drain: every request emits one pending result
                emit    = 1'b1;
                rd_addr = out_col_reg;
                req.src = (out_row_reg >= h_last) ? SRC_MIDDLE : SRC_EDGE;
            end
            else if (kind == KIND_TILE)
            begin
                req.writes = 1'b1;
                req.tile   = tile;
                emit       = due;
                if (in_col_reg == '0)
                    req.src = SRC_EDGE;
                else if (interior)
                    req.src = SRC_COUNT;
                else
                    req.src = SRC_CENTER;

                if (in_col_reg >= w_last)
                begin
                    in_col_next = '0;
                    if (in_row_reg >= h_last)
                        taken_next = 1'b1;
                    else
                        in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
        end

        if (emit)
        begin
            req.due    = 1'b1;
            req.last   = is_last;
            req.column = POS_W'(out_col_reg);
            req.row    = POS_W'(out_row_reg);
            if (is_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                taken_next   = 1'b0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (out_col_reg >= w_last)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        req_act = accept && (taken_reg || (kind == KIND_TILE));

        if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
                begin
                    if (cfg_index == REG_FRAME_WIDTH)
                        width_next = cfg_data;
                    else
                        height_next = cfg_data;
                    in_col_next  = '0;
                    in_row_next  = '0;
                    taken_next   = 1'b0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                REG_WALL_THRESHOLD:
                begin
                    thr_next = cfg_data[THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_FRAME_WIDTH;
            height_reg  <= RST_FRAME_HEIGHT;
            thr_reg     <= RST_WALL_THRESHOLD;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            taken_reg   <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            thr_reg     <= thr_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            taken_reg   <= taken_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cas_stencil.sv @@
`default_nettype none

module cas_stencil #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire cas_pkg::stage_ctl_t                req,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]       req_addr,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]       w_last,
    input  wire logic [cas_pkg::THR_W-1:0]          threshold,
    input  wire logic                               rd_upper,
    input  wire logic                               rd_middle,
    output logic                                    free,
    output logic                                    wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]            wr_addr,
    output logic                                    wr_upper,
    output logic                                    wr_middle,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic [cas_pkg::POS_W-1:0]               column,
    output logic [cas_pkg::POS_W-1:0]               row,
    output logic                                    tile_out,
    output logic                                    last
);
    import cas_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             s1_valid_reg, s1_valid_next;
    stage_ctl_t       s1_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [8:0]       window_reg, window_next;
    logic             edge_reg;
    logic             out_valid_reg, out_valid_next;
    logic             done;
    logic             value;
    logic [3:0]       count;

    assign done  = s1_valid_reg && (!s1_reg.due || !out_valid_reg || result_ready);
    assign free  = !s1_valid_reg || done;

    // window columns: [2:0] two back, [5:3] one back, [8:6] newest (upper, middle, tile)
    assign window_next = {s1_reg.tile, rd_middle, rd_upper, window_reg[8:3]};

    always_comb
    begin
        count = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
                count = count + 4'(window_next[i]);
        end
    end

    always_comb
    begin
        case (s1_reg.src)
            SRC_EDGE:   value = edge_reg;
            SRC_CENTER: value = window_next[4];
            SRC_COUNT:  value = (count >= threshold);
            SRC_MIDDLE: value = rd_middle;
            default:    value = 1'b0;
        endcase
    end

    assign wr_en     = done && s1_reg.writes;
    assign wr_addr   = s1_addr_reg;
    assign wr_upper  = rd_middle;
    assign wr_middle = s1_reg.tile;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
            s1_valid_next = 1'b1;
        else if (done)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (done && s1_reg.due)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
                window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg      <= req;
            s1_addr_reg <= req_addr;
        end
        // right-border copy of the upper line
        if (wr_en && (s1_addr_reg == w_last))
            edge_reg <= rd_middle;
        if (done && s1_reg.due)
        begin
            column   <= s1_reg.column;
            row      <= s1_reg.row;
            tile_out <= value;
            last     <= s1_reg.last;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/cas_checker.sv @@
`default_nettype none

module cas_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       tile_valid,
    input wire logic       tile_ready,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [9:0] column,
    input wire logic [9:0] row,
    input wire logic       tile_out,
    input wire logic       last
);

    // nothing is offered during reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result offered during reset");

    // a new result always stems from an earlier taken request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(tile_valid && tile_ready, 2))
        else $error("result without a matching request");

    // with no result waiting, the block always takes requests
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> tile_ready)
        else $error("request refused while output is empty");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(column) && $stable(row) &&
            $stable(tile_out) && $stable(last))
        else $error("stalled result changed");

endmodule

bind cellular_automaton_smoothing cas_checker u_cas_checker (.*);

`default_nettype wire
